>>> src/bcpe_pkg.sv
// ============================================================================
// bcpe_pkg
// Shared types, sizes and controller codes for the bezier curve point
// evaluator.
// ============================================================================
`default_nettype none

package bcpe_pkg;

    // sizing
    localparam int MAX_POINTS = 8;
    localparam int COORD_BITS = 10;

    localparam int INDEX_W    = 3;
    localparam int PARAM_W    = 17;
    localparam int FRAC_W     = 16;
    localparam int OUT_FRAC   = 8;
    localparam int OUT_W      = COORD_BITS + OUT_FRAC;
    localparam int CFG_W      = 4;
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(2);
    localparam logic [PARAM_W-1:0] ONE_Q16 = PARAM_W'(65536);

    // de casteljau word sizes: a level input stays below 2^MAG_W,
    // a level output below 2^ACC_W
    localparam int DEG_W      = $clog2(MAX_POINTS);
    localparam int MAG_W      = COORD_BITS + FRAC_W * (MAX_POINTS - 2);
    localparam int ACC_W      = MAG_W + FRAC_W;
    localparam int LIMB_W     = 32;
    localparam int LIMB_COUNT = (MAG_W + LIMB_W - 1) / LIMB_W;
    localparam int DIFF_W     = LIMB_COUNT * LIMB_W;
    localparam int LIMB_IDX_W = (LIMB_COUNT > 1) ? $clog2(LIMB_COUNT) : 1;
    localparam int PROD_W     = LIMB_W + PARAM_W;
    localparam int RND_W      = ACC_W + OUT_FRAC + 2;

    typedef struct packed {
        logic                  mode;
        logic [INDEX_W-1:0]    point_index;
        logic [COORD_BITS-1:0] point_x;
        logic [COORD_BITS-1:0] point_y;
        logic [PARAM_W-1:0]    curve_param;
    } item_t;

    typedef struct packed {
        logic [OUT_W-1:0] curve_x;
        logic [OUT_W-1:0] curve_y;
    } result_t;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_EVAL = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_MAC,
        ST_PUSH,
        ST_ROUND
    } ctrl_state_t;

    // controller to datapath commands
    typedef struct packed {
        logic                  write_point;
        logic                  load_ring;
        logic                  diff;
        logic                  mac;
        logic                  shift;
        logic                  push;
        logic                  round;
        logic [LIMB_IDX_W-1:0] limb;
        logic [DEG_W-1:0]      deg;
    } dp_cmd_t;

endpackage

`default_nettype wire

>>> src/bezier_curve_point_evaluator_unit.sv
// ============================================================================
// bezier_curve_point_evaluator_unit
// 2-d bezier curve point evaluator, exact de casteljau in fixed point with
// one rounding to q10.8.
// ============================================================================
//
// usage
// - command channel: a beat is taken at a clock edge with start high and
//   busy low. mode 0 loads item.point_x/point_y into table entry
//   item.point_index at that edge and gives no result; busy stays low.
//   mode 1 evaluates the curve at item.curve_param (q0.16, 1.0 = 65536).
// - config channel: cfg_data is the point count, taken when cfg_valid and
//   cfg_ready are high; cfg_ready is high whenever busy is low.
// - result: result.curve_x/curve_y are shown with done high for one cycle;
//   the receiver cannot stall, so nothing waits on it. the result registers
//   hold until the next evaluation rounds.
// - timing: busy stays high while an evaluate beat is worked off, and done
//   is high in the first cycle with busy low again, the cycle in which busy
//   falls. a new beat can be taken in the done cycle.
// - cost is set by the single 32x17 multiplier per lane: each de casteljau
//   combination takes a difference step, four limb steps and a write back
//   step, and every level walks the eight-entry ring once
// - reset: point count returns to 2, control returns to idle; table
//   entries hold garbage until loaded
//
// ============================================================================
`default_nettype none

module bezier_curve_point_evaluator_unit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // command channel
    input  wire logic                        start,
    input  wire bcpe_pkg::item_t             item,
    output logic                             busy,
    // config channel
    input  wire logic                        cfg_valid,
    input  wire logic [bcpe_pkg::CFG_W-1:0]  cfg_data,
    output logic                             cfg_ready,
    // result channel
    output bcpe_pkg::result_t                result,
    output logic                             done
);

    // command bundle from the sequencer to the arithmetic
    bcpe_pkg::dp_cmd_t cmd;

    // sequencer: level, ring step and limb counters plus point count
    bcpe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .mode      (item.mode),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cfg_ready (cfg_ready),
        .busy      (busy),
        .cmd       (cmd)
    );

    // point table, x/y rings, multiply accumulate, rounding
    bcpe_datapath u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .result (result),
        .done   (done)
    );

endmodule

`default_nettype wire

>>> src/bcpe_ctrl.sv
// ============================================================================
// bcpe_ctrl
// Sequencer for the de casteljau levels, ring steps and limb-serial
// multiply; holds the point count register.
// ============================================================================
`default_nettype none

module bcpe_ctrl (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic                        mode,
    input  wire logic                        cfg_valid,
    input  wire logic [bcpe_pkg::CFG_W-1:0]  cfg_data,
    output logic                             cfg_ready,
    output logic                             busy,
    output bcpe_pkg::dp_cmd_t                cmd
);

    bcpe_pkg::ctrl_state_t state_reg, state_next;

    logic [bcpe_pkg::CFG_W-1:0]      count_reg;
    logic [bcpe_pkg::DEG_W-1:0]      deg_reg, deg_next;
    logic [bcpe_pkg::DEG_W-1:0]      level_reg, level_next;
    logic [bcpe_pkg::DEG_W-1:0]      step_reg, step_next;
    logic [bcpe_pkg::LIMB_IDX_W-1:0] limb_reg, limb_next;

    logic [bcpe_pkg::DEG_W-1:0] deg_cfg;
    logic                       eval_accept;
    logic                       is_combo;
    logic                       last_step;
    logic                       last_level;
    logic                       last_limb;

    // degree from point count, clamped to 1..max points
    always_comb
    begin
        if (count_reg == '0)
            deg_cfg = '0;
        else if (int'(count_reg) > bcpe_pkg::MAX_POINTS)
            deg_cfg = bcpe_pkg::DEG_W'(bcpe_pkg::MAX_POINTS - 1);
        else
            deg_cfg = bcpe_pkg::DEG_W'(int'(count_reg) - 1);
    end

    assign busy        = (state_reg != bcpe_pkg::ST_IDLE);
    assign cfg_ready   = ~busy;
    assign eval_accept = start && !busy && (mode == bcpe_pkg::MODE_EVAL);

    assign is_combo   = int'(step_reg) < (int'(deg_reg) - int'(level_reg));
    assign last_step  = (step_reg == bcpe_pkg::DEG_W'(bcpe_pkg::MAX_POINTS - 1));
    assign last_level = (level_reg == deg_reg - bcpe_pkg::DEG_W'(1));
    assign last_limb  = (limb_reg == bcpe_pkg::LIMB_IDX_W'(bcpe_pkg::LIMB_COUNT - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bcpe_pkg::ST_IDLE;
            count_reg <= bcpe_pkg::CFG_RESET;
            deg_reg   <= '0;
            level_reg <= '0;
            step_reg  <= '0;
            limb_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            deg_reg   <= deg_next;
            level_reg <= level_next;
            step_reg  <= step_next;
            limb_reg  <= limb_next;
            if (cfg_valid && cfg_ready)
                count_reg <= cfg_data;
        end
    end

    // next state and counters
    always_comb
    begin
        state_next = state_reg;
        deg_next   = deg_reg;
        level_next = level_reg;
        step_next  = step_reg;
        limb_next  = limb_reg;
        unique case (state_reg)
            bcpe_pkg::ST_IDLE:
            begin
                if (eval_accept)
                begin
                    deg_next   = deg_cfg;
                    level_next = '0;
                    step_next  = '0;
                    limb_next  = '0;
                    state_next = (deg_cfg == '0) ? bcpe_pkg::ST_ROUND : bcpe_pkg::ST_STEP;
                end
            end
            bcpe_pkg::ST_STEP:
            begin
                if (is_combo)
                begin
                    limb_next  = '0;
                    state_next = bcpe_pkg::ST_MAC;
                end
                else if (last_step)
                begin
                    step_next = '0;
                    if (last_level)
                        state_next = bcpe_pkg::ST_ROUND;
                    else
                        level_next = level_reg + bcpe_pkg::DEG_W'(1);
                end
                else
                    step_next = step_reg + bcpe_pkg::DEG_W'(1);
            end
            bcpe_pkg::ST_MAC:
            begin
                if (last_limb)
                    state_next = bcpe_pkg::ST_PUSH;
                else
                    limb_next = limb_reg + bcpe_pkg::LIMB_IDX_W'(1);
            end
            bcpe_pkg::ST_PUSH:
            begin
                // a combo step never is the last ring step
                step_next  = step_reg + bcpe_pkg::DEG_W'(1);
                state_next = bcpe_pkg::ST_STEP;
            end
            bcpe_pkg::ST_ROUND:
            begin
                state_next = bcpe_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = bcpe_pkg::ST_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd             = '0;
        cmd.limb        = limb_reg;
        cmd.deg         = deg_reg;
        unique case (state_reg)
            bcpe_pkg::ST_IDLE:
            begin
                cmd.write_point = start && (mode == bcpe_pkg::MODE_LOAD);
                cmd.load_ring   = eval_accept;
            end
            bcpe_pkg::ST_STEP:
            begin
                cmd.diff  = is_combo;
                cmd.shift = !is_combo;
            end
            bcpe_pkg::ST_MAC:
            begin
                cmd.mac = 1'b1;
            end
            bcpe_pkg::ST_PUSH:
            begin
                cmd.shift = 1'b1;
                cmd.push  = 1'b1;
            end
            bcpe_pkg::ST_ROUND:
            begin
                cmd.round = 1'b1;
            end
            default:
            begin
                cmd.round = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> src/bcpe_datapath.sv
// ============================================================================
// bcpe_datapath
// Point table, two-lane de casteljau ring with limb-serial multiply
// accumulate, and the final rounding to q10.8.
// ============================================================================
`default_nettype none

module bcpe_datapath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire bcpe_pkg::item_t    item,
    input  wire bcpe_pkg::dp_cmd_t  cmd,
    output bcpe_pkg::result_t       result,
    output logic                    done
);

    localparam int NLANE = 2;

    logic [2*bcpe_pkg::COORD_BITS-1:0] pts_reg [bcpe_pkg::MAX_POINTS];
    logic [bcpe_pkg::ACC_W-1:0]        ring_reg [NLANE][bcpe_pkg::MAX_POINTS];
    logic [bcpe_pkg::ACC_W-1:0]        acc_reg  [NLANE];
    logic [bcpe_pkg::ACC_W-1:0]        acc_next [NLANE];
    logic [bcpe_pkg::DIFF_W-1:0]       diff_reg [NLANE];
    logic [bcpe_pkg::DIFF_W-1:0]       diff_next[NLANE];
    logic                              neg_reg  [NLANE];
    logic                              neg_next [NLANE];
    logic [bcpe_pkg::PARAM_W-1:0]      u_reg;
    logic [bcpe_pkg::OUT_W-1:0]        out_reg  [NLANE];
    logic [bcpe_pkg::OUT_W-1:0]        out_next [NLANE];
    logic                              done_reg;

    always_comb
    begin
        logic [bcpe_pkg::DIFF_W-1:0] a0;
        logic [bcpe_pkg::DIFF_W-1:0] a1;
        logic [bcpe_pkg::LIMB_W-1:0] limb_val;
        logic [bcpe_pkg::PROD_W-1:0] prod;
        logic [bcpe_pkg::ACC_W-1:0]  pp;
        logic [bcpe_pkg::RND_W-1:0]  rnd;
        for (int l = 0; l < NLANE; l++)
        begin
            // head difference, magnitude and sign
            a0 = bcpe_pkg::DIFF_W'(ring_reg[l][0][bcpe_pkg::MAG_W-1:0]);
            a1 = bcpe_pkg::DIFF_W'(ring_reg[l][1][bcpe_pkg::MAG_W-1:0]);
            neg_next[l]  = (a1 < a0);
            diff_next[l] = (a1 < a0) ? (a0 - a1) : (a1 - a0);

            // one limb of u * |b1 - b0|
            limb_val = diff_reg[l][cmd.limb*bcpe_pkg::LIMB_W +: bcpe_pkg::LIMB_W];
            prod     = bcpe_pkg::PROD_W'(limb_val) * bcpe_pkg::PROD_W'(u_reg);
            pp       = bcpe_pkg::ACC_W'(prod) << (bcpe_pkg::LIMB_W * int'(cmd.limb));
            if (cmd.diff)
                acc_next[l] = ring_reg[l][0] << bcpe_pkg::FRAC_W;
            else if (neg_reg[l])
                acc_next[l] = acc_reg[l] - pp;
            else
                acc_next[l] = acc_reg[l] + pp;

            // round to nearest 1/256, ties up
            rnd = (bcpe_pkg::RND_W'(ring_reg[l][0]) << (bcpe_pkg::OUT_FRAC + 1))
                + (bcpe_pkg::RND_W'(1) << (bcpe_pkg::FRAC_W * int'(cmd.deg)));
            out_next[l] = bcpe_pkg::OUT_W'(rnd >> (bcpe_pkg::FRAC_W * int'(cmd.deg) + 1));
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < bcpe_pkg::MAX_POINTS; i++)
        begin
            if (cmd.write_point && int'(item.point_index) == i)
                pts_reg[i] <= {item.point_y, item.point_x};
        end

        if (cmd.load_ring)
            u_reg <= item.curve_param[bcpe_pkg::PARAM_W-1] ? bcpe_pkg::ONE_Q16
                                                           : item.curve_param;

        for (int l = 0; l < NLANE; l++)
        begin
            if (cmd.load_ring)
            begin
                for (int i = 0; i < bcpe_pkg::MAX_POINTS; i++)
                    ring_reg[l][i] <= bcpe_pkg::ACC_W'(
                        pts_reg[i][l*bcpe_pkg::COORD_BITS +: bcpe_pkg::COORD_BITS]);
            end
            else if (cmd.shift)
            begin
                for (int i = 0; i < bcpe_pkg::MAX_POINTS - 1; i++)
                    ring_reg[l][i] <= ring_reg[l][i+1];
                ring_reg[l][bcpe_pkg::MAX_POINTS-1] <= cmd.push ? acc_reg[l] : ring_reg[l][0];
            end

            if (cmd.diff)
            begin
                diff_reg[l] <= diff_next[l];
                neg_reg[l]  <= neg_next[l];
            end
            if (cmd.diff || cmd.mac)
                acc_reg[l] <= acc_next[l];
            if (cmd.round)
                out_reg[l] <= out_next[l];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cmd.round;
    end

    assign result.curve_x = out_reg[0];
    assign result.curve_y = out_reg[1];
    assign done           = done_reg;

endmodule

`default_nettype wire

>>> src/bcpe_checker.sv
// ============================================================================
// bcpe_checker
// Port-level checks on command and result timing of the evaluator.
// ============================================================================
`default_nettype none

module bcpe_checker (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire bcpe_pkg::item_t  item,
    input  wire logic             busy,
    input  wire logic             done
);

    // a result is only shown once the unit is free again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    // strobe lasts one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one beat");

    // evaluate beat makes the unit busy
    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.mode == bcpe_pkg::MODE_EVAL) |=> busy)
        else $error("evaluate beat did not start work");

    // load beat gives no result
    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.mode == bcpe_pkg::MODE_LOAD) |=> (!busy && !done))
        else $error("load beat caused work or result");

    // end of work always comes with a result
    a_end_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("work ended without result");

endmodule

bind bezier_curve_point_evaluator_unit bcpe_checker u_bcpe_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .item  (item),
    .busy  (busy),
    .done  (done)
);

`default_nettype wire
